@@ rtl/hsb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the HSB to RGB555 color converter.
// No dependencies; used by every module of the block.
package hsb_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 15;
  localparam int SECT_W  = 3;
  localparam int HUEX_W  = 11;

  // Full-scale channel level.
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Color wheel sectors, in the order the scaled hue walks through them.
  localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
  localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
  localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
  localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
  localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
  localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic              grey;
    logic [SECT_W-1:0] sector;
    logic [CHAN_W-1:0] offset;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
  } item_t;

endpackage

@@ rtl/hsb_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input items and classifies them into sector and offset.
// Depends on hsb_pkg.
module hsb_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsb_pkg::CHAN_W-1:0]  in_hue,
  input  logic [hsb_pkg::CHAN_W-1:0]  in_saturation,
  input  logic [hsb_pkg::CHAN_W-1:0]  in_brightness,
  input  logic                        q_full,
  output logic                        q_push,
  output hsb_pkg::item_t              q_item
);

  logic [hsb_pkg::HUEX_W-1:0] hue_x6;

  // Accept whenever the queue has room.
  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

  // Hue times six as two shifted adds; the top bits give the sector.
  assign hue_x6 = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

  always_comb begin
    q_item.grey   = (in_saturation == '0);
    q_item.sector = hue_x6[hsb_pkg::HUEX_W-1:hsb_pkg::CHAN_W];
    q_item.offset = hue_x6[hsb_pkg::CHAN_W-1:0];
    q_item.sat    = in_saturation;
    q_item.bri    = in_brightness;
  end

endmodule

@@ rtl/hsb_fifo.sv @@
`timescale 1ns / 1ps
// Small queue of classified items between the front and the back.
// Depends on hsb_pkg for the item type.
module hsb_fifo #(
  parameter int DEPTH = hsb_pkg::QUEUE_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hsb_pkg::item_t   wr_item,
  input  logic             pop,
  output hsb_pkg::item_t   rd_item,
  output logic             rd_valid,
  output logic             full,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  hsb_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer advance with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Item storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item  = mem_r[rd_ptr_r];
  assign rd_valid = (count_r != '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign count    = count_r;

endmodule

@@ rtl/hsb_back.sv @@
`timescale 1ns / 1ps
// Back end: two-stage pipeline that forms p, q, t and packs the RGB555 color.
// Depends on hsb_pkg.
module hsb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  hsb_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsb_pkg::COLOR_W-1:0]  out_color
);

  localparam int CW = hsb_pkg::CHAN_W;

  // Stage one registers.
  logic                       s1_valid_r;
  logic                       s1_grey_r;
  logic [hsb_pkg::SECT_W-1:0] s1_sector_r;
  logic [CW-1:0]              s1_bri_r;
  logic [CW-1:0]              s1_sinv_r;
  logic [CW-1:0]              s1_so_r, s1_so_nxt;
  logic [CW-1:0]              s1_sno_r, s1_sno_nxt;

  // Output register.
  logic                         out_valid_r;
  logic [hsb_pkg::COLOR_W-1:0]  out_color_r, out_color_nxt;

  logic          s2_load;
  logic          s1_load;
  logic [2*CW-1:0] so_prod, sno_prod;
  logic [2*CW-1:0] p_prod, q_prod, t_prod;
  logic [CW-1:0]   p_val, q_val, t_val;
  logic [CW-1:0]   r_val, g_val, b_val;

  // Pipeline advance: each stage loads when the one after it frees up.
  assign s2_load = ~out_valid_r | out_ready;
  assign s1_load = ~s1_valid_r | s2_load;
  assign q_pop   = q_valid & s1_load;

  // Stage one: saturation scaled by the offset and by its complement.
  assign so_prod    = q_item.sat * q_item.offset;
  assign sno_prod   = q_item.sat * (hsb_pkg::CHAN_MAX - q_item.offset);
  assign s1_so_nxt  = so_prod[2*CW-1:CW];
  assign s1_sno_nxt = sno_prod[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_grey_r   <= q_item.grey;
      s1_sector_r <= q_item.sector;
      s1_bri_r    <= q_item.bri;
      s1_sinv_r   <= hsb_pkg::CHAN_MAX - q_item.sat;
      s1_so_r     <= s1_so_nxt;
      s1_sno_r    <= s1_sno_nxt;
    end
  end

  // Stage two: brightness-scaled p, q and t terms.
  assign p_prod = s1_bri_r * s1_sinv_r;
  assign q_prod = s1_bri_r * (hsb_pkg::CHAN_MAX - s1_so_r);
  assign t_prod = s1_bri_r * (hsb_pkg::CHAN_MAX - s1_sno_r);
  assign p_val  = p_prod[2*CW-1:CW];
  assign q_val  = q_prod[2*CW-1:CW];
  assign t_val  = t_prod[2*CW-1:CW];

  // Per-sector channel assignment; grey overrides all three channels.
  always_comb begin
    case (s1_sector_r)
      hsb_pkg::SECT_RED_YEL: begin
        r_val = s1_bri_r; g_val = t_val;    b_val = p_val;
      end
      hsb_pkg::SECT_YEL_GRN: begin
        r_val = q_val;    g_val = s1_bri_r; b_val = p_val;
      end
      hsb_pkg::SECT_GRN_CYN: begin
        r_val = p_val;    g_val = s1_bri_r; b_val = t_val;
      end
      hsb_pkg::SECT_CYN_BLU: begin
        r_val = p_val;    g_val = q_val;    b_val = s1_bri_r;
      end
      hsb_pkg::SECT_BLU_MAG: begin
        r_val = t_val;    g_val = p_val;    b_val = s1_bri_r;
      end
      default: begin
        r_val = s1_bri_r; g_val = p_val;    b_val = q_val;
      end
    endcase
    if (s1_grey_r) begin
      r_val = s1_bri_r;
      g_val = s1_bri_r;
      b_val = s1_bri_r;
    end
    out_color_nxt = {r_val[CW-1:3], g_val[CW-1:3], b_val[CW-1:3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_color_r <= out_color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_color = out_color_r;

endmodule

@@ rtl/hsb_to_rgb555_core.sv @@
`timescale 1ns / 1ps
// Converts 8-bit hue, saturation and brightness to a packed RGB555 color.
// Top level; depends on hsb_pkg, hsb_front, hsb_fifo and hsb_back.
//
// Each accepted item gives exactly one color, red in bits 14..10, green in
// 9..5 and blue in 4..0, in the order the items came in. The block takes one
// item per clock cycle and returns one per cycle while out_ready stays high.
// From acceptance to the output an item passes the input queue, the stage
// that scales saturation by the hue offset, and the stage that scales by
// brightness and fills the output register. The queue of QUEUE_DEPTH
// entries holds items while the output is stalled, and in_ready drops
// only when that queue is full. Reset is synchronous and active low; the
// block keeps no state between items.
module hsb_to_rgb555_core #(
  parameter int QUEUE_DEPTH = hsb_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsb_pkg::CHAN_W-1:0]   in_hue,
  input  logic [hsb_pkg::CHAN_W-1:0]   in_saturation,
  input  logic [hsb_pkg::CHAN_W-1:0]   in_brightness,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsb_pkg::COLOR_W-1:0]  out_color
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  logic [CNT_W-1:0] q_count;
  hsb_pkg::item_t   front_item;
  hsb_pkg::item_t   back_item;

  // Front end: handshake and hue classification.
  hsb_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (front_item)
  );

  // Queue between the two halves.
  hsb_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (front_item),
    .pop      (q_pop),
    .rd_item  (back_item),
    .rd_valid (q_valid),
    .full     (q_full),
    .count    (q_count)
  );

  // Back end: arithmetic pipeline and output register.
  hsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (back_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (out_color)
  );

`ifndef ASSERT_OFF
  // The back end only takes an item from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // The queue never holds more items than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(q_count) <= QUEUE_DEPTH)
    else $error("queue count above depth");

  // The fill count follows pushes and pops exactly.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      (int'(q_count) == int'($past(q_count)) + int'($past(q_push))
                        - int'($past(q_pop))))
    else $error("queue count does not match pushes and pops");
`endif

endmodule

@@ dv/hsb_to_rgb555_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsb_to_rgb555_core: corner-case and random pixels
// pass through with random stalls on both handshakes. Depends on hsb_pkg and the core RTL.
module hsb_to_rgb555_core_tb;

  localparam int RANDOM_PIXELS = 1050;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 12;
  localparam int IDLE_PERCENT  = 31;
  localparam int MAX_REPORTS   = 10;
  localparam int CW            = hsb_pkg::CHAN_W;

  // Scoreboard: predicts the packed color of each accepted pixel and checks
  // the results in arrival order.
  class color_scoreboard;
    logic [hsb_pkg::COLOR_W-1:0] pending_colors[$];
    int unsigned mismatches = 0;

    // Truncating product of two 8-bit levels, scaled back to 8 bits.
    function logic [CW-1:0] frac_mul(logic [CW-1:0] a, logic [CW-1:0] b);
      logic [2*CW-1:0] prod;
      prod = a * b;
      return prod[2*CW-1:CW];
    endfunction

    function logic [hsb_pkg::COLOR_W-1:0] rgb555_of(logic [CW-1:0] h, logic [CW-1:0] s,
                                                    logic [CW-1:0] v);
      logic [hsb_pkg::HUEX_W-1:0] hx;
      logic [hsb_pkg::SECT_W-1:0] sector;
      logic [CW-1:0] off, p, q, t, r, g, b;
      hx     = h * 11'd6;
      sector = hx[hsb_pkg::HUEX_W-1:CW];
      off    = hx[CW-1:0];
      p      = frac_mul(v, hsb_pkg::CHAN_MAX - s);
      q      = frac_mul(v, hsb_pkg::CHAN_MAX - frac_mul(s, off));
      t      = frac_mul(v, hsb_pkg::CHAN_MAX - frac_mul(s, hsb_pkg::CHAN_MAX - off));
      if (s == '0) begin
        // Grey: hue plays no part.
        r = v;
        g = v;
        b = v;
      end else begin
        case (sector)
          hsb_pkg::SECT_RED_YEL: begin r = v; g = t; b = p; end
          hsb_pkg::SECT_YEL_GRN: begin r = q; g = v; b = p; end
          hsb_pkg::SECT_GRN_CYN: begin r = p; g = v; b = t; end
          hsb_pkg::SECT_CYN_BLU: begin r = p; g = q; b = v; end
          hsb_pkg::SECT_BLU_MAG: begin r = t; g = p; b = v; end
          default:               begin r = v; g = p; b = q; end
        endcase
      end
      return {r[CW-1:3], g[CW-1:3], b[CW-1:3]};
    endfunction

    function void note_pixel(logic [CW-1:0] h, logic [CW-1:0] s, logic [CW-1:0] v);
      pending_colors.push_back(rgb555_of(h, s, v));
    endfunction

    function void check_color(logic [hsb_pkg::COLOR_W-1:0] seen);
      logic [hsb_pkg::COLOR_W-1:0] want;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected color %h with no pixel outstanding", seen);
      end else begin
        want = pending_colors.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("color mismatch: expected %h (r %0d g %0d b %0d), got %h (r %0d g %0d b %0d)",
                     want, want[14:10], want[9:5], want[4:0],
                     seen, seen[14:10], seen[9:5], seen[4:0]);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic [CW-1:0]                in_hue        = '0;
  logic [CW-1:0]                in_saturation = '0;
  logic [CW-1:0]                in_brightness = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic [hsb_pkg::COLOR_W-1:0]  out_color;

  // Set during a stretch of the run in which neither side idles.
  bit                  steady        = 1'b0;
  int unsigned         cycle_count   = 0;
  color_scoreboard     board         = new();

  hsb_to_rgb555_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_color     (out_color)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Offers one pixel after a random gap and returns at the edge where it is taken.
  task automatic send_pixel(input logic [CW-1:0] h, input logic [CW-1:0] s,
                            input logic [CW-1:0] v);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pixel(h, s, v);
  endtask

  // Result side: check each accepted color and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_color(out_color);
    out_ready <= rst_n && !take_break();
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CW-1:0] h, s, v;
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Grey pixels: hue must not matter.
    send_pixel(8'd0,   8'd0, 8'd0);
    send_pixel(8'd77,  8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128);
    // Fully saturated, full brightness on both sides of every sector boundary.
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd42,  8'd255, 8'd255);
    send_pixel(8'd43,  8'd255, 8'd255);
    send_pixel(8'd85,  8'd255, 8'd255);
    send_pixel(8'd86,  8'd255, 8'd255);
    send_pixel(8'd127, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd255, 8'd255);
    send_pixel(8'd171, 8'd255, 8'd255);
    send_pixel(8'd213, 8'd255, 8'd255);
    send_pixel(8'd214, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    // Black, barely saturated, near-black and a zero offset within a sector.
    send_pixel(8'd200, 8'd255, 8'd0);
    send_pixel(8'd100, 8'd1,   8'd255);
    send_pixel(8'd30,  8'd128, 8'd1);
    send_pixel(8'd128, 8'd200, 8'd200);
    send_pixel(8'd5,   8'd170, 8'd90);
    send_pixel(8'd60,  8'd255, 8'd7);

    // Random pixels, about a third of them pushed toward the field extremes.
    for (i = 0; i < RANDOM_PIXELS; i++) begin
      steady = (i >= 400) && (i < 650);
      h = CW'($urandom_range(255));
      s = CW'($urandom_range(255));
      v = CW'($urandom_range(255));
      if ($urandom_range(9) < 3) begin
        s = $urandom_range(1) ? hsb_pkg::CHAN_MAX : CW'($urandom_range(2));
        if ($urandom_range(1)) v = $urandom_range(1) ? hsb_pkg::CHAN_MAX : '0;
      end
      send_pixel(h, s, v);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Drain, then give stray results a chance to show up.
    while (board.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_colors.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
